FILE: sv/obda_pkg.sv
// Shared constants and types of the order book depth aggregator.
package obda_pkg;

    localparam int PRICE_W = 20;
    localparam int QTY_W   = 16;
    localparam int TOTAL_W = 32;
    localparam int DEPTH_W = 6;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 32'hFFFF_FFFF;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    localparam logic SIDE_SELL = 1'b0;
    localparam logic SIDE_BUY  = 1'b1;

    localparam logic REG_DEPTH = 1'b0;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_HOLD = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
    localparam logic [OP_W-1:0] OP_ROTL = 2'd2;
    localparam logic [OP_W-1:0] OP_ROTR = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [QTY_W-1:0] qty;
    } t_cell_ctl;

endpackage

FILE: sv/obda_cell.sv
// One price level cell: compare, insert, shift, accumulate and rotate.
module obda_cell import obda_pkg::*; #(
    parameter bit BUY = 1'b0,
    parameter int PW  = 20
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [PW-1:0]      i_new_price,
    input  logic               i_any_eq,
    input  logic               i_occupied,
    input  logic               i_prev_better,
    input  logic [PW-1:0]      i_prev_price,
    input  logic [TOTAL_W-1:0] i_prev_total,
    input  logic [PW-1:0]      i_next_price,
    input  logic [TOTAL_W-1:0] i_next_total,
    output logic               o_better,
    output logic               o_equal,
    output logic [PW-1:0]      o_price,
    output logic [TOTAL_W-1:0] o_total
);

    logic [PW-1:0]      r_price;
    logic [TOTAL_W-1:0] r_total;
    logic [PW-1:0]      n_price;
    logic [TOTAL_W-1:0] n_total;
    logic [TOTAL_W:0]   w_sum;

    assign o_better = i_occupied &&
                      (BUY ? (r_price > i_new_price) : (r_price < i_new_price));
    assign o_equal  = i_occupied && (r_price == i_new_price);
    assign w_sum    = {1'b0, r_total} + (TOTAL_W + 1)'(i_ctl.qty);

    always_comb begin
        n_price = r_price;
        n_total = r_total;
        case (i_ctl.op)
            OP_ADD: begin
                if (i_any_eq) begin
                    if (o_equal) begin
                        n_total = w_sum[TOTAL_W] ? TOTAL_MAX : w_sum[TOTAL_W-1:0];
                    end
                end else if (i_prev_better && !o_better) begin
                    n_price = i_new_price;
                    n_total = TOTAL_W'(i_ctl.qty);
                end else if (!i_prev_better) begin
                    n_price = i_prev_price;
                    n_total = i_prev_total;
                end
            end
            OP_ROTL: begin
                n_price = i_next_price;
                n_total = i_next_total;
            end
            OP_ROTR: begin
                n_price = i_prev_price;
                n_total = i_prev_total;
            end
            default: begin
                n_price = r_price;
                n_total = r_total;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_price <= n_price;
        r_total <= n_total;
    end

    assign o_price = r_price;
    assign o_total = r_total;

endmodule

FILE: sv/obda_side.sv
// Sorted row of price level cells for one side of the book, with its level count.
module obda_side import obda_pkg::*; #(
    parameter bit BUY    = 1'b0,
    parameter int LEVELS = 32,
    parameter int PW     = 20,
    parameter int CW     = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [PW-1:0]      i_new_price,
    output logic [CW-1:0]      o_count,
    output logic [PW-1:0]      o_head_price,
    output logic [TOTAL_W-1:0] o_head_total
);

    logic [PW-1:0]      w_price [LEVELS];
    logic [TOTAL_W-1:0] w_total [LEVELS];
    logic [LEVELS-1:0]  w_better;
    logic [LEVELS-1:0]  w_equal;
    logic               w_any_eq;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    assign w_any_eq = |w_equal;

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        localparam int PREV = (g == 0) ? LEVELS - 1 : g - 1;
        localparam int NEXT = (g == LEVELS - 1) ? 0 : g + 1;
        logic w_prev_better;

        assign w_prev_better = (g == 0) ? 1'b1 : w_better[PREV];

        obda_cell #(
            .BUY (BUY),
            .PW  (PW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (i_ctl),
            .i_new_price   (i_new_price),
            .i_any_eq      (w_any_eq),
            .i_occupied    (CW'(g) < r_count),
            .i_prev_better (w_prev_better),
            .i_prev_price  (w_price[PREV]),
            .i_prev_total  (w_total[PREV]),
            .i_next_price  (w_price[NEXT]),
            .i_next_total  (w_total[NEXT]),
            .o_better      (w_better[g]),
            .o_equal       (w_equal[g]),
            .o_price       (w_price[g]),
            .o_total       (w_total[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.op == OP_ADD && !w_any_eq && !w_better[LEVELS-1] &&
            r_count != CW'(LEVELS)) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count      = r_count;
    assign o_head_price = BUY ? w_price[0] : w_price[LEVELS-1];
    assign o_head_total = BUY ? w_total[0] : w_total[LEVELS-1];

endmodule

FILE: sv/order_book_depth_aggregator_unit.sv
// Add item: a new add item is accepted in every cycle while no report runs.
// Report item: each side's cell row rotates one full turn past its end cell,
// one level per cycle while the output is not stalled, so storage is restored.
// The input is stalled while a report runs; results leave through an output register.
// Reset clears both level counts and sets depth to 32; level storage is not cleared.
module order_book_depth_aggregator_unit import obda_pkg::*; #(
    parameter int LEVELS     = 32,
    parameter int PRICE_BITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic               i_side,
    input  logic [PRICE_W-1:0] i_price,
    input  logic [QTY_W-1:0]   i_quantity,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_out_side,
    output logic [PRICE_W-1:0] o_level_price,
    output logic [TOTAL_W-1:0] o_level_quantity,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int PW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int CW = $clog2(LEVELS + 1);
    localparam int SW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SELL = 2'd1;
    localparam logic [1:0] ST_BUY  = 2'd2;

    logic [DEPTH_W-1:0] r_depth;
    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [SW-1:0]      r_step;
    logic [SW-1:0]      n_step;
    logic [CW-1:0]      r_ns;
    logic [CW-1:0]      r_nb;
    logic [CW-1:0]      n_ns;
    logic [CW-1:0]      n_nb;

    logic               r_out_valid;
    logic               r_out_side;
    logic [PW-1:0]      r_out_price;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_last;

    t_cell_ctl          w_sell_ctl;
    t_cell_ctl          w_buy_ctl;
    logic [CW-1:0]      w_sell_count;
    logic [CW-1:0]      w_buy_count;
    logic [PW-1:0]      w_sell_price;
    logic [PW-1:0]      w_buy_price;
    logic [TOTAL_W-1:0] w_sell_total;
    logic [TOTAL_W-1:0] w_buy_total;

    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_emit;
    logic               w_emit_last;
    logic               w_advance;
    logic               w_step_end;

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_DEPTH) ? APB_DW'(r_depth) : '0;
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step_end = (r_step == SW'(LEVELS - 1));

    always_comb begin
        w_emit      = 1'b0;
        w_emit_last = 1'b0;
        case (r_state)
            ST_SELL: begin
                w_emit = ((CW + 1)'(r_step) + (CW + 1)'(r_ns)) >= (CW + 1)'(LEVELS);
                w_emit_last = w_step_end && (r_nb == '0);
            end
            ST_BUY: begin
                w_emit      = CW'(r_step) < r_nb;
                w_emit_last = (CW'(r_step) + CW'(1)) == r_nb;
            end
            default: begin
                w_emit      = 1'b0;
                w_emit_last = 1'b0;
            end
        endcase
    end

    assign w_advance = (r_state != ST_IDLE) && (!w_emit || w_out_free);

    always_comb begin
        n_ns = (DEPTH_W'(w_sell_count) < r_depth) ? w_sell_count : r_depth[CW-1:0];
        n_nb = (DEPTH_W'(w_buy_count) < r_depth) ? w_buy_count : r_depth[CW-1:0];
    end

    always_comb begin
        w_sell_ctl.op  = OP_HOLD;
        w_sell_ctl.qty = i_quantity;
        w_buy_ctl.op   = OP_HOLD;
        w_buy_ctl.qty  = i_quantity;
        if (w_in_xfer && i_func == FUNC_ADD) begin
            if (i_side == SIDE_BUY) begin
                w_buy_ctl.op = OP_ADD;
            end else begin
                w_sell_ctl.op = OP_ADD;
            end
        end
        if (w_advance && r_state == ST_SELL) begin
            w_sell_ctl.op = OP_ROTR;
        end
        if (w_advance && r_state == ST_BUY) begin
            w_buy_ctl.op = OP_ROTL;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && i_func == FUNC_REPORT) begin
                    n_state = ST_SELL;
                    n_step  = '0;
                end
            end
            ST_SELL: begin
                if (w_advance) begin
                    n_step = r_step + SW'(1);
                    if (w_step_end) begin
                        n_state = ST_BUY;
                        n_step  = '0;
                    end
                end
            end
            ST_BUY: begin
                if (w_advance) begin
                    n_step = r_step + SW'(1);
                    if (w_step_end) begin
                        n_state = ST_IDLE;
                        n_step  = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= DEPTH_RESET;
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_DEPTH) begin
                r_depth <= pwdata[DEPTH_W-1:0];
            end
            r_state <= n_state;
            r_step  <= n_step;
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && i_func == FUNC_REPORT) begin
            r_ns <= n_ns;
            r_nb <= n_nb;
        end
        if (w_advance && w_emit) begin
            r_out_side  <= (r_state == ST_BUY) ? SIDE_BUY : SIDE_SELL;
            r_out_price <= (r_state == ST_BUY) ? w_buy_price : w_sell_price;
            r_out_total <= (r_state == ST_BUY) ? w_buy_total : w_sell_total;
            r_out_last  <= w_emit_last;
        end
    end

    obda_side #(
        .BUY    (1'b0),
        .LEVELS (LEVELS),
        .PW     (PW),
        .CW     (CW)
    ) u_sell (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_sell_ctl),
        .i_new_price  (i_price[PW-1:0]),
        .o_count      (w_sell_count),
        .o_head_price (w_sell_price),
        .o_head_total (w_sell_total)
    );

    obda_side #(
        .BUY    (1'b1),
        .LEVELS (LEVELS),
        .PW     (PW),
        .CW     (CW)
    ) u_buy (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_buy_ctl),
        .i_new_price  (i_price[PW-1:0]),
        .o_count      (w_buy_count),
        .o_head_price (w_buy_price),
        .o_head_total (w_buy_total)
    );

    assign o_out_valid      = r_out_valid;
    assign o_out_side       = r_out_side;
    assign o_level_price    = PRICE_W'(r_out_price);
    assign o_level_quantity = r_out_total;
    assign o_last           = r_out_last;

endmodule
